### rtl/ole_pkg.sv
// Shared types and constants for the ordered list engine.
package ole_pkg;

    localparam int CAPACITY = 256;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 3;
    localparam int POS_W    = 9;
    localparam int IN_DATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((STAT_W + POS_W + CNT_W + 7) / 8) * 8;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_INS_AT    = 3'd2,
        REQ_RM_FRONT  = 3'd3,
        REQ_RM_BACK   = 3'd4,
        REQ_RM_VALUE  = 3'd5,
        REQ_SEARCH    = 3'd6,
        REQ_REVERSE   = 3'd7
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_RANGE  = 3'd1,
        STAT_EMPTY  = 3'd2,
        STAT_ABSENT = 3'd3,
        STAT_FULL   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ALLOC,
        ST_INS,
        ST_WALK,
        ST_FIX,
        ST_FREE,
        ST_DONE
    } t_state;

    // Access bundle for the slot store: one read address for both arrays,
    // one write port on each array.
    typedef struct packed {
        t_slot             rd_addr;
        logic              lk_we;
        t_slot             lk_waddr;
        t_slot             lk_wdata;
        logic              it_we;
        t_slot             it_waddr;
        logic [VAL_W-1:0]  it_wdata;
    } t_store_req;

endpackage

### rtl/ole_store.sv
// Slot store: item values and successor links, registered read data.
module ole_store (
    input  logic                      i_clk,
    input  ole_pkg::t_store_req       i_req,
    output ole_pkg::t_slot            o_link_q,
    output logic [ole_pkg::VAL_W-1:0] o_item_q
);
    import ole_pkg::*;

    t_slot            r_links [CAPACITY];
    logic [VAL_W-1:0] r_items [CAPACITY];
    t_slot            r_link_q;
    logic [VAL_W-1:0] r_item_q;

    always_ff @(posedge i_clk) begin
        if (i_req.lk_we) begin
            r_links[i_req.lk_waddr] <= i_req.lk_wdata;
        end
        r_link_q <= r_links[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.it_we) begin
            r_items[i_req.it_waddr] <= i_req.it_wdata;
        end
        r_item_q <= r_items[i_req.rd_addr];
    end

    assign o_link_q = r_link_q;
    assign o_item_q = r_item_q;

endmodule

### rtl/ordered_list_engine.sv
// Top level of the ordered list engine: request sequencer, list registers, result register.
// Sequence: an error found in DECIDE goes straight to DONE; insert at the front or back passes
//   through INS (after ALLOC when a released slot is reused), remove back of a one-item list
//   through FREE and remove front through WALK and FREE. A walk (search, remove by value,
//   remove back, positional insert, reverse) visits one item per cycle; the result then
//   waits in DONE while the output register holds a result that i_m_tready has not taken.
// Flow: one request at a time; the next is taken in IDLE, which follows the loading of the result
//   before it. The walk steps one item per cycle, set by the single read port of the link store.
// Reset: synchronous, active low; empties the list, the free chain and the result register.
module ordered_list_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata, lowest bit up: position[8:0], value[40:9], zero pad
    input  logic [ole_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: req_type[2:0]
    input  logic [ole_pkg::REQ_W-1:0]      i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata, lowest bit up: status[2:0], found_position[11:3], item_count[20:12], zero pad
    output logic [ole_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import ole_pkg::*;

    // Sequencer and list registers
    t_state            r_state, n_state;
    t_slot             r_head, n_head;
    t_slot             r_tail, n_tail;
    t_cnt              r_count, n_count;
    t_slot             r_free_head, n_free_head;
    t_cnt              r_free_n, n_free_n;
    t_slot             r_fresh, n_fresh;
    logic              r_m_valid, n_m_valid;

    // Per-transaction working registers (no reset needed)
    t_req              r_req;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_val;
    t_slot             r_cur, n_cur;
    t_slot             r_prev, n_prev;
    t_slot             r_slot, n_slot;
    t_slot             r_save, n_save;
    t_slot             r_idx, n_idx;
    t_slot             r_tgt, n_tgt;
    t_slot             r_last, n_last;
    t_status           r_status, n_status;
    logic [POS_W-1:0]  r_found, n_found;
    logic [OUT_DATA_W-1:0] r_m_data, n_m_data;

    t_store_req        w_sreq;
    t_slot             w_link_q;
    logic [VAL_W-1:0]  w_item_q;

    logic w_accept, w_full, w_range, w_empty, w_single, w_match, w_at_last, w_at_tgt;
    logic w_out_free, w_is_ins, w_ins_front, w_ins_back, w_have_free;

    ole_store u_store (
        .i_clk    (i_clk),
        .i_req    (w_sreq),
        .o_link_q (w_link_q),
        .o_item_q (w_item_q)
    );

    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_range     = (CNT_W'(r_pos) > r_count);
    assign w_empty     = (r_count == '0);
    assign w_single    = (r_count == CNT_W'(1));
    assign w_have_free = (r_free_n != '0);
    // The shared compare unit of the walk: value match and position checks
    assign w_match     = (w_item_q == r_val);
    assign w_at_last   = (r_idx == r_last);
    assign w_at_tgt    = (r_idx == r_tgt);
    assign w_out_free  = !r_m_valid || i_m_tready;
    assign w_is_ins    = r_req inside {REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT};
    assign w_ins_front = (r_req == REQ_INS_FRONT) || ((r_req == REQ_INS_AT) && (r_pos == '0));
    assign w_ins_back  = (r_req == REQ_INS_BACK)
                      || ((r_req == REQ_INS_AT) && (CNT_W'(r_pos) == r_count));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                case (r_req)
                    REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
                        if (w_full || ((r_req == REQ_INS_AT) && w_range)) begin
                            n_state = ST_DONE;
                        end else if (w_have_free) begin
                            n_state = ST_ALLOC;
                        end else begin
                            n_state = ST_INS;
                        end
                    end
                    REQ_RM_BACK: begin
                        if (w_empty)       n_state = ST_DONE;
                        else if (w_single) n_state = ST_FREE;
                        else               n_state = ST_WALK;
                    end
                    REQ_REVERSE: begin
                        n_state = (w_empty || w_single) ? ST_DONE : ST_WALK;
                    end
                    default: begin
                        n_state = w_empty ? ST_DONE : ST_WALK;
                    end
                endcase
            end
            ST_ALLOC: n_state = ST_INS;
            ST_INS: begin
                n_state = (w_ins_front || w_ins_back) ? ST_DONE : ST_WALK;
            end
            ST_WALK: begin
                case (r_req)
                    REQ_INS_AT:   if (w_at_tgt) n_state = ST_FIX;
                    REQ_RM_FRONT: n_state = ST_FREE;
                    REQ_RM_BACK:  if (w_at_tgt) n_state = ST_FREE;
                    REQ_RM_VALUE: begin
                        if (w_match)        n_state = ST_FREE;
                        else if (w_at_last) n_state = ST_DONE;
                    end
                    REQ_SEARCH:   if (w_match || w_at_last) n_state = ST_DONE;
                    REQ_REVERSE:  if (w_at_last) n_state = ST_DONE;
                    default:      n_state = ST_DONE;
                endcase
            end
            ST_FIX:  n_state = ST_DONE;
            ST_FREE: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and store accesses
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_free_head = r_free_head;
        n_free_n    = r_free_n;
        n_fresh     = r_fresh;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_slot      = r_slot;
        n_save      = r_save;
        n_idx       = r_idx;
        n_tgt       = r_tgt;
        n_last      = r_last;
        n_status    = r_status;
        n_found     = r_found;
        n_m_data    = r_m_data;
        n_m_valid   = i_m_tready ? 1'b0 : r_m_valid;

        w_sreq          = '0;
        w_sreq.rd_addr  = r_head;
        w_sreq.it_waddr = r_slot;
        w_sreq.it_wdata = r_val;

        case (r_state)
            ST_IDLE: begin
                n_status = STAT_OK;
                n_found  = '1;
            end
            ST_DECIDE: begin
                // Read the free chain head for inserts, the list head otherwise
                w_sreq.rd_addr = w_is_ins ? r_free_head : r_head;
                n_cur  = r_head;
                n_prev = r_head;
                n_idx  = '0;
                n_last = SLOT_W'(r_count - CNT_W'(1));
                case (r_req)
                    REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
                        if ((r_req == REQ_INS_AT) && w_range) begin
                            n_status = STAT_RANGE;
                        end else if (w_full) begin
                            n_status = STAT_FULL;
                        end else if (!w_have_free) begin
                            n_slot  = r_fresh;
                            n_fresh = r_fresh + SLOT_W'(1);
                        end
                    end
                    REQ_RM_FRONT: begin
                        if (w_empty) n_status = STAT_EMPTY;
                        n_tgt = '0;
                    end
                    REQ_RM_BACK: begin
                        if (w_empty) n_status = STAT_EMPTY;
                        n_slot = r_head;
                        n_tgt  = SLOT_W'(r_count - CNT_W'(2));
                    end
                    REQ_RM_VALUE: begin
                        if (w_empty) n_status = STAT_EMPTY;
                    end
                    REQ_SEARCH: begin
                        if (w_empty) n_status = STAT_ABSENT;
                    end
                    default: ;
                endcase
            end
            ST_ALLOC: begin
                // Pop the free chain: take its head, advance to the next free slot
                n_slot      = r_free_head;
                n_free_head = w_link_q;
                n_free_n    = r_free_n - CNT_W'(1);
            end
            ST_INS: begin
                w_sreq.it_we = 1'b1;
                if (w_ins_front) begin
                    if (w_empty) begin
                        n_tail = r_slot;
                    end else begin
                        w_sreq.lk_we    = 1'b1;
                        w_sreq.lk_waddr = r_slot;
                        w_sreq.lk_wdata = r_head;
                    end
                    n_head  = r_slot;
                    n_count = r_count + CNT_W'(1);
                end else if (w_ins_back) begin
                    if (w_empty) begin
                        n_head = r_slot;
                    end else begin
                        w_sreq.lk_we    = 1'b1;
                        w_sreq.lk_waddr = r_tail;
                        w_sreq.lk_wdata = r_slot;
                    end
                    n_tail  = r_slot;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    // Walk to the item before the insertion point
                    w_sreq.rd_addr = r_head;
                    n_cur  = r_head;
                    n_prev = r_head;
                    n_idx  = '0;
                    n_tgt  = SLOT_W'(r_pos - POS_W'(1));
                end
            end
            ST_WALK: begin
                // Read data belongs to r_cur; prefetch its successor
                w_sreq.rd_addr = w_link_q;
                case (r_req)
                    REQ_INS_AT: begin
                        if (w_at_tgt) begin
                            w_sreq.lk_we    = 1'b1;
                            w_sreq.lk_waddr = r_cur;
                            w_sreq.lk_wdata = r_slot;
                            n_save          = w_link_q;
                        end
                    end
                    REQ_RM_FRONT: begin
                        n_head = w_link_q;
                        n_slot = r_cur;
                    end
                    REQ_RM_BACK: begin
                        if (w_at_tgt) begin
                            n_tail = r_cur;
                            n_slot = r_tail;
                        end
                    end
                    REQ_RM_VALUE: begin
                        if (w_match) begin
                            n_slot = r_cur;
                            if (r_idx == '0) begin
                                n_head = w_link_q;
                            end else begin
                                // Unlink: predecessor skips the matched item
                                w_sreq.lk_we    = 1'b1;
                                w_sreq.lk_waddr = r_prev;
                                w_sreq.lk_wdata = w_link_q;
                                if (w_at_last) n_tail = r_prev;
                            end
                        end else if (w_at_last) begin
                            n_status = STAT_ABSENT;
                        end
                    end
                    REQ_SEARCH: begin
                        if (w_match) begin
                            n_found = POS_W'(r_idx);
                        end else if (w_at_last) begin
                            n_status = STAT_ABSENT;
                        end
                    end
                    REQ_REVERSE: begin
                        // Point the current item back at its predecessor
                        w_sreq.lk_we    = 1'b1;
                        w_sreq.lk_waddr = r_cur;
                        w_sreq.lk_wdata = r_prev;
                        if (w_at_last) begin
                            n_head = r_cur;
                            n_tail = r_head;
                        end
                    end
                    default: ;
                endcase
                n_prev = r_cur;
                n_cur  = w_link_q;
                n_idx  = r_idx + SLOT_W'(1);
            end
            ST_FIX: begin
                w_sreq.lk_we    = 1'b1;
                w_sreq.lk_waddr = r_slot;
                w_sreq.lk_wdata = r_save;
                n_count         = r_count + CNT_W'(1);
            end
            ST_FREE: begin
                // Push the released slot onto the free chain
                w_sreq.lk_we    = 1'b1;
                w_sreq.lk_waddr = r_slot;
                w_sreq.lk_wdata = r_free_head;
                n_free_head     = r_slot;
                n_free_n        = r_free_n + CNT_W'(1);
                n_count         = r_count - CNT_W'(1);
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = OUT_DATA_W'({r_count, r_found, r_status});
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_free_head <= '0;
            r_free_n    <= '0;
            r_fresh     <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_free_head <= n_free_head;
            r_free_n    <= n_free_n;
            r_fresh     <= n_fresh;
            r_m_valid   <= n_m_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= t_req'(i_s_tuser);
            r_pos <= i_s_tdata[POS_W-1:0];
            r_val <= i_s_tdata[POS_W+VAL_W-1:POS_W];
        end
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_slot   <= n_slot;
        r_save   <= n_save;
        r_idx    <= n_idx;
        r_tgt    <= n_tgt;
        r_last   <= n_last;
        r_status <= n_status;
        r_found  <= n_found;
        r_m_data <= n_m_data;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // Held items never exceed capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("item count above capacity");

    // Held plus released slots never exceed capacity
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} + {1'b0, r_free_n}) <= (CNT_W + 1)'(CAPACITY))
        else $error("slot accounting broken");

    // The walk never runs past the last item
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_idx <= r_last))
        else $error("walk ran past list end");

    // Count moves only in insert, link fix-up or release steps
    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_INS && r_state != ST_FIX && r_state != ST_FREE) |=> $stable(r_count))
        else $error("count changed outside an update step");

    // A result is loaded only when the output register is free
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_m_valid && !i_m_tready) |=> (r_state == ST_DONE))
        else $error("result left while output stalled");

endmodule

### tb/tb_ordered_list_engine.sv
// Testbench for the ordered list engine: queue-based predictor with randomized stream traffic.
`timescale 1ns / 1ps

module tb_ordered_list_engine;
    import ole_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 300;   // a bit more than one full-length list walk
    localparam int RANDOM_ITEMS = 1200;
    localparam int REPORT_MAX   = 10;
    localparam logic [POS_W-1:0] NO_MATCH = '1;  // -1 in the found_position field

    typedef enum int {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIXED
    } t_segment;

    typedef struct {
        t_req              kind;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
    } list_request;

    typedef struct {
        t_status           status;
        logic [POS_W-1:0]  found;
        logic [CNT_W-1:0]  count;
    } list_response;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [REQ_W-1:0]      i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    ordered_list_engine DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Mirror of the list contents, front first.
    logic [VAL_W-1:0] list_items[$];
    list_response     expected_responses[$];
    list_request      pending_requests[$];
    list_request      driven_request;

    int  queued_total;
    int  accepted_total;
    int  mismatches;
    int  quiet_cycles;
    int  send_gap;
    int  stall_left;
    bit  request_taken;
    bit  traffic_gaps;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Random pause length: mostly none, sometimes short, rarely long.
    function automatic int draw_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (!traffic_gaps || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        // Small pool so that searches and removals by value hit often.
        if (roll < 5) return $urandom_range(0, 15) - 8;
        return $urandom();
    endfunction

    // Prefer a value currently held so that lookups find something.
    function automatic logic [VAL_W-1:0] held_value();
        if (list_items.size() > 0 && $urandom_range(0, 9) < 6)
            return list_items[$urandom_range(0, list_items.size() - 1)];
        return rand_value();
    endfunction

    function automatic void queue_request(t_req kind, int position,
                                          logic [VAL_W-1:0] value);
        list_request item;
        item.kind     = kind;
        item.position = POS_W'(position);
        item.value    = value;
        pending_requests.push_back(item);
        queued_total++;
    endfunction

    // Apply one request to the mirrored list and queue the response it must produce.
    function automatic void apply_list_request(t_req kind, logic [POS_W-1:0] position,
                                               logic [VAL_W-1:0] value);
        list_response     resp;
        logic [VAL_W-1:0] flipped[$];
        int               hit;
        int               i;
        resp.status = STAT_OK;
        resp.found  = NO_MATCH;
        hit = -1;
        for (i = 0; i < list_items.size(); i++) begin
            if (list_items[i] == value) begin
                hit = i;
                break;
            end
        end
        case (kind)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (list_items.size() >= CAPACITY)
                    resp.status = STAT_FULL;
                else if (kind == REQ_INS_FRONT)
                    list_items.push_front(value);
                else
                    list_items.push_back(value);
            end
            REQ_INS_AT: begin
                // Range is checked ahead of fullness.
                if (position > list_items.size())
                    resp.status = STAT_RANGE;
                else if (list_items.size() >= CAPACITY)
                    resp.status = STAT_FULL;
                else
                    list_items.insert(position, value);
            end
            REQ_RM_FRONT: begin
                if (list_items.size() == 0)
                    resp.status = STAT_EMPTY;
                else
                    void'(list_items.pop_front());
            end
            REQ_RM_BACK: begin
                if (list_items.size() == 0)
                    resp.status = STAT_EMPTY;
                else
                    void'(list_items.pop_back());
            end
            REQ_RM_VALUE: begin
                if (list_items.size() == 0)
                    resp.status = STAT_EMPTY;
                else if (hit < 0)
                    resp.status = STAT_ABSENT;
                else
                    list_items.delete(hit);
            end
            REQ_SEARCH: begin
                if (hit < 0)
                    resp.status = STAT_ABSENT;
                else
                    resp.found = hit[POS_W-1:0];
            end
            default: begin
                foreach (list_items[i]) flipped.push_front(list_items[i]);
                list_items = flipped;
            end
        endcase
        resp.count = CNT_W'(list_items.size());
        expected_responses.push_back(resp);
    endfunction

    // Compare one result transaction with the oldest pending response.
    function automatic void check_response(logic [OUT_DATA_W-1:0] word);
        list_response     want;
        logic [STAT_W-1:0] got_status;
        logic [POS_W-1:0]  got_found;
        logic [CNT_W-1:0]  got_count;
        got_status = word[2:0];
        got_found  = word[11:3];
        got_count  = word[20:12];
        if (expected_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("result with nothing pending: status %0d found %h count %0d",
                         got_status, got_found, got_count);
            return;
        end
        want = expected_responses.pop_front();
        if (got_status !== want.status || got_found !== want.found
                || got_count !== want.count) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch: expected status %0d found %h count %0d, got status %0d found %h count %0d",
                         want.status, want.found, want.count, got_status, got_found, got_count);
        end
    endfunction

    // Sender and receiver: drive at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            if (!i_s_tvalid || request_taken) begin
                request_taken = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    driven_request = pending_requests.pop_front();
                    i_s_tdata  <= {7'b0, driven_request.value, driven_request.position};
                    i_s_tuser  <= driven_request.kind;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = draw_pause();
            end
        end
    end

    // Sample both sides at the rising edge; watch for a hung block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (i_s_tvalid && o_s_tready) begin
                request_taken = 1'b1;
                send_gap = draw_pause();
                accepted_total++;
                quiet_cycles = 0;
                apply_list_request(t_req'(i_s_tuser), i_s_tdata[8:0], i_s_tdata[40:9]);
            end
            if (o_m_tvalid && i_m_tready) begin
                quiet_cycles = 0;
                check_response(o_m_tdata);
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[ordered_list_engine] ERROR");
                $finish;
            end
        end
    end

    // Block until every queued transaction has been accepted and answered.
    task automatic wait_for_idle();
        while (accepted_total != queued_total || expected_responses.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        t_segment segment;
        int       random_sent;
        int       start_len;
        int       est;
        int       n;
        int       k;
        int       roll;

        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = REQ_INS_FRONT;
        i_m_tready    = 1'b0;
        send_gap      = 0;
        stall_left    = 0;
        request_taken = 1'b0;
        traffic_gaps  = 1'b1;
        queued_total  = 0;
        accepted_total = 0;
        mismatches    = 0;
        random_sent   = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-list corner cases, then a small list through every request.
        queue_request(REQ_RM_FRONT, 0, 32'd0);
        queue_request(REQ_RM_BACK, 0, 32'd0);
        queue_request(REQ_RM_VALUE, 0, 32'd0);
        queue_request(REQ_SEARCH, 0, 32'd0);
        queue_request(REQ_REVERSE, 0, 32'd0);
        queue_request(REQ_INS_AT, 1, 32'd5);
        queue_request(REQ_INS_AT, 511, 32'd5);
        queue_request(REQ_INS_AT, 0, 32'h7FFF_FFFF);
        queue_request(REQ_REVERSE, 0, 32'd0);
        queue_request(REQ_RM_VALUE, 0, 32'h7FFF_FFFF);   // remove the only item
        queue_request(REQ_INS_BACK, 0, 32'h8000_0000);
        queue_request(REQ_RM_BACK, 0, 32'd0);            // last one out from the back
        queue_request(REQ_INS_FRONT, 0, 32'hFFFF_FFFF);
        queue_request(REQ_INS_BACK, 0, 32'd0);
        queue_request(REQ_INS_AT, 1, 32'h8000_0000);     // middle insert
        queue_request(REQ_INS_AT, 3, 32'h7FFF_FFFF);     // insert at current length
        queue_request(REQ_SEARCH, 0, 32'h7FFF_FFFF);
        queue_request(REQ_SEARCH, 0, 32'd12345);
        queue_request(REQ_REVERSE, 0, 32'd0);
        queue_request(REQ_SEARCH, 0, 32'h7FFF_FFFF);
        queue_request(REQ_RM_VALUE, 0, 32'd0);           // middle removal
        queue_request(REQ_RM_VALUE, 0, 32'hFFFF_FFFF);   // tail removal
        queue_request(REQ_RM_FRONT, 0, 32'd0);
        queue_request(REQ_RM_BACK, 0, 32'd0);
        queue_request(REQ_RM_VALUE, 0, 32'd55);
        wait_for_idle();

        // Random segments, each shaped from the list length at its start.
        while (random_sent < RANDOM_ITEMS) begin
            start_len = list_items.size();
            roll = $urandom_range(0, 99);
            if (random_sent == 0 || roll < 10)
                segment = SEG_FILL;
            else if (roll < 25)
                segment = SEG_DRAIN;
            else
                segment = SEG_MIXED;
            // Leave some segments with no gaps or stalls at all.
            traffic_gaps = ($urandom_range(0, 3) != 0);

            case (segment)
                SEG_FILL: begin
                    // Grow to capacity, then knock on the full list a few times.
                    n = CAPACITY - start_len + $urandom_range(2, 5);
                    for (k = 0; k < n; k++) begin
                        est = (start_len + k < CAPACITY) ? start_len + k : CAPACITY;
                        case ($urandom_range(0, 2))
                            0: queue_request(REQ_INS_FRONT, $urandom_range(0, 511), rand_value());
                            1: queue_request(REQ_INS_BACK, $urandom_range(0, 511), rand_value());
                            default: queue_request(REQ_INS_AT, $urandom_range(0, est), rand_value());
                        endcase
                    end
                end
                SEG_DRAIN: begin
                    n = start_len + $urandom_range(2, 4);
                    for (k = 0; k < n; k++) begin
                        case ($urandom_range(0, 2))
                            0: queue_request(REQ_RM_FRONT, $urandom_range(0, 511), rand_value());
                            1: queue_request(REQ_RM_BACK, $urandom_range(0, 511), rand_value());
                            default: queue_request(REQ_RM_VALUE, $urandom_range(0, 511), held_value());
                        endcase
                    end
                end
                default: begin
                    n = $urandom_range(30, 60);
                    for (k = 0; k < n; k++) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 12)
                            queue_request(REQ_INS_FRONT, $urandom_range(0, 511), rand_value());
                        else if (roll < 24)
                            queue_request(REQ_INS_BACK, $urandom_range(0, 511), rand_value());
                        else if (roll < 38)
                            queue_request(REQ_INS_AT, $urandom_range(0, start_len + 1), rand_value());
                        else if (roll < 44)
                            queue_request(REQ_INS_AT, $urandom_range(0, 511), rand_value());
                        else if (roll < 52)
                            queue_request(REQ_RM_FRONT, $urandom_range(0, 511), rand_value());
                        else if (roll < 60)
                            queue_request(REQ_RM_BACK, $urandom_range(0, 511), rand_value());
                        else if (roll < 72)
                            queue_request(REQ_RM_VALUE, $urandom_range(0, 511), held_value());
                        else if (roll < 92)
                            queue_request(REQ_SEARCH, $urandom_range(0, 511), held_value());
                        else
                            queue_request(REQ_REVERSE, $urandom_range(0, 511), rand_value());
                    end
                end
            endcase
            random_sent += n;
            wait_for_idle();
        end

        // Hold long enough for any stray result to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ordered_list_engine] OK");
        else
            $display("[ordered_list_engine] ERROR");
        $finish;
    end

endmodule
